// File: rtl/core/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry block.
`default_nettype none
package ddo_pkg;

    // Widths fixed by the item fields and registers.
    localparam int COUNT_W  = 32;
    localparam int GAIN_W   = 32;
    localparam int POS_W    = 48;
    localparam int ANGLE_W  = 32;
    localparam int CFG_IDX_W = 1;

    // CORDIC settings. The arctangent table has 32 entries, so a step index is 5 bits.
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int STEP_IDX_W       = 5;
    localparam int CW               = 34;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    // Reset values of the gain registers.
    localparam logic [GAIN_W-1:0] METRES_GAIN_RST = 32'd73986;
    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST  = 32'd40062;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_METRES_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 1'b1;

    // Operation codes of an input item.
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    // Position range and the travel cap that keeps the clipping outcome.
    localparam logic signed [51:0] POS_MAX = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] POS_MIN = -52'sh0_8000_0000_0000;
    localparam logic [65:0] DX_CAP = 66'd1 << 49;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE, ST_MULS, ST_MULA, ST_CINIT, ST_CROT, ST_CFIN,
        ST_MHI, ST_MLO, ST_SCALE, ST_ACC, ST_OUT
    } t_state;

    // Datapath commands.
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_MULS, CMD_MULA, CMD_CINIT, CMD_CSTEP,
        CMD_CFIN, CMD_MHI, CMD_MLO, CMD_SCALE, CMD_ACC, CMD_OUT
    } t_cmd;

    // Command word from controller to datapath.
    typedef struct packed {
        t_cmd                  cmd;
        logic                  axis;
        logic [STEP_IDX_W-1:0] step;
    } t_ctl;

    // Rounded binary-angle arctangent of 2^-i.
    function automatic logic [31:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ddo_in_if.sv
// Input channel: encoder counts and operation, with valid/ready handshake.
`default_nettype none
interface ddo_in_if;
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic signed [31:0]    left_count;
    logic signed [31:0]    right_count;

    modport source (output valid, operation, left_count, right_count, input ready);
    modport sink   (input valid, operation, left_count, right_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ddo_out_if.sv
// Output channel: pose result, with valid/ready handshake.
`default_nettype none
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
    logic               saturated;

    modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ddo_dp.sv
// Odometry datapath: gains, baselines, pose, shared multiplier and CORDIC rotator.
`default_nettype none
module ddo_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ddo_pkg::t_ctl                   i_ctl,
    input  wire logic                            i_cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ddo_pkg::GAIN_W-1:0]      i_cfg_data,
    input  wire logic [ddo_pkg::COUNT_W-1:0]     i_left_count,
    input  wire logic [ddo_pkg::COUNT_W-1:0]     i_right_count,
    output logic signed [ddo_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]     o_pos_y,
    output logic [ddo_pkg::ANGLE_W-1:0]          o_heading,
    output logic                                 o_saturated
);
    import ddo_pkg::*;

    logic [GAIN_W-1:0]        r_gain_m, r_gain_a;
    logic [COUNT_W-1:0]       r_lbase, r_rbase;
    logic signed [POS_W-1:0]  r_x, r_y;
    logic [31:0]              r_hd;
    logic                     r_sat;
    logic                     r_sneg;
    logic [32:0]              r_smag;
    logic [32:0]              r_diff;
    logic [63:0]              r_dsmag;
    logic [31:0]              r_dtheta, r_half;
    logic signed [CW-1:0]     r_cx, r_cy, r_cz;
    logic                     r_flip;
    logic [31:0]              r_cmag [2];
    logic                     r_neg  [2];
    logic [63:0]              r_phi, r_plo;
    logic signed [50:0]       r_d;

    logic [COUNT_W-1:0]       dl, dr;
    logic signed [32:0]       sum33, diff33;
    logic [32:0]              mul_a, mul_b;
    logic [65:0]              mul_p;
    logic [31:0]              mid, ang;
    logic                     flip;
    logic signed [CW-1:0]     xs, ys, atn;
    logic signed [CW-1:0]     cs, sn, cabs, sabs;
    logic [65:0]              full;
    logic [49:0]              mag;
    logic signed [POS_W-1:0]  pos;
    logic signed [51:0]       acc;

    // Count deltas modulo 2^32, their sum and difference.
    always_comb begin
        dl     = i_left_count - r_lbase;
        dr     = i_right_count - r_rbase;
        sum33  = $signed({dl[31], dl}) + $signed({dr[31], dr});
        diff33 = $signed({dr[31], dr}) - $signed({dl[31], dl});
    end

    // Shared multiplier with operand selection by command.
    always_comb begin
        unique case (i_ctl.cmd)
            CMD_MULS: begin mul_a = r_smag; mul_b = {1'b0, r_gain_m}; end
            CMD_MULA: begin mul_a = r_diff; mul_b = {1'b0, r_gain_a}; end
            CMD_MHI: begin
                mul_a = {1'b0, r_dsmag[63:32]};
                mul_b = {1'b0, r_cmag[i_ctl.axis]};
            end
            CMD_MLO: begin
                mul_a = {1'b0, r_dsmag[31:0]};
                mul_b = {1'b0, r_cmag[i_ctl.axis]};
            end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = {33'd0, mul_a} * {33'd0, mul_b};
    end

    // Midpoint heading folded into the right half plane.
    always_comb begin
        mid  = r_hd + r_half;
        flip = (mid[31:30] == 2'b01) || (mid[31:30] == 2'b10);
        ang  = flip ? (mid + 32'h8000_0000) : mid;
    end

    // One CORDIC rotation step with floor shifts.
    always_comb begin
        xs  = r_cx >>> i_ctl.step;
        ys  = r_cy >>> i_ctl.step;
        atn = $signed({2'b00, atan_lut(i_ctl.step)});
    end

    // Final cosine and sine with the half-turn correction, as sign and magnitude.
    always_comb begin
        cs   = r_flip ? -r_cx : r_cx;
        sn   = r_flip ? -r_cy : r_cy;
        cabs = cs[CW-1] ? -cs : cs;
        sabs = sn[CW-1] ? -sn : sn;
    end

    // Scaled travel magnitude, capped, and the saturating accumulate.
    always_comb begin
        full = {r_phi, 2'b00} + {32'd0, r_plo[63:30]};
        mag  = (full > DX_CAP) ? DX_CAP[49:0] : full[49:0];
        pos  = i_ctl.axis ? r_y : r_x;
        acc  = {{4{pos[POS_W-1]}}, pos} + {r_d[50], r_d};
    end

    // Configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_m <= METRES_GAIN_RST;
            r_gain_a <= ANGLE_GAIN_RST;
            r_lbase  <= '0;
            r_rbase  <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_hd     <= '0;
            r_sat    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_METRES_GAIN: r_gain_m <= i_cfg_data;
                    REG_ANGLE_GAIN:  r_gain_a <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_lbase <= i_left_count;
                    r_rbase <= i_right_count;
                    r_sat   <= 1'b0;
                end
                CMD_CFIN: r_hd <= r_hd + r_dtheta;
                CMD_ACC: begin
                    if (acc > POS_MAX) begin
                        r_sat <= 1'b1;
                        if (i_ctl.axis) r_y <= POS_MAX[POS_W-1:0];
                        else            r_x <= POS_MAX[POS_W-1:0];
                    end else if (acc < POS_MIN) begin
                        r_sat <= 1'b1;
                        if (i_ctl.axis) r_y <= POS_MIN[POS_W-1:0];
                        else            r_x <= POS_MIN[POS_W-1:0];
                    end else begin
                        if (i_ctl.axis) r_y <= acc[POS_W-1:0];
                        else            r_x <= acc[POS_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of one update.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                r_sneg <= sum33[32];
                r_smag <= sum33[32] ? 33'(-sum33) : 33'(sum33);
                r_diff <= diff33;
            end
            CMD_MULS: r_dsmag <= mul_p[64:1];
            CMD_MULA: begin
                r_dtheta <= mul_p[31:0];
                r_half   <= mul_p[32:1];
            end
            CMD_CINIT: begin
                r_cx   <= CORDIC_K;
                r_cy   <= '0;
                r_cz   <= CW'($signed(ang));
                r_flip <= flip;
            end
            CMD_CSTEP: begin
                if (!r_cz[CW-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atn;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atn;
                end
            end
            CMD_CFIN: begin
                r_cmag[0] <= cabs[31:0];
                r_cmag[1] <= sabs[31:0];
                r_neg[0]  <= r_sneg ^ cs[CW-1];
                r_neg[1]  <= r_sneg ^ sn[CW-1];
            end
            CMD_MHI:   r_phi <= mul_p[63:0];
            CMD_MLO:   r_plo <= mul_p[63:0];
            CMD_SCALE: begin
                r_d <= r_neg[i_ctl.axis] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            CMD_OUT: begin
                o_pos_x     <= r_x;
                o_pos_y     <= r_y;
                o_heading   <= r_hd;
                o_saturated <= r_sat;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/ddo_ctrl.sv
// Odometry controller: sequences one item through the datapath and owns the handshakes.
`default_nettype none
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_in_op,
    output logic        o_in_ready,
    input  wire logic   i_out_ready,
    output logic        o_out_valid,
    output ddo_pkg::t_ctl o_ctl
);
    import ddo_pkg::*;

    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    t_state         r_state, n_state;
    logic [SW-1:0]  r_step, n_step;
    logic           r_axis, n_axis;
    logic           r_out_valid, n_out_valid;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_ctl.cmd   = CMD_NONE;
        o_ctl.axis  = r_axis;
        o_ctl.step  = STEP_IDX_W'(r_step);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = (i_in_op == OP_CAPTURE) ? ST_OUT : ST_MULS;
                end
            end
            ST_MULS: begin
                o_ctl.cmd = CMD_MULS;
                n_state   = ST_MULA;
            end
            ST_MULA: begin
                o_ctl.cmd = CMD_MULA;
                n_state   = ST_CINIT;
            end
            ST_CINIT: begin
                o_ctl.cmd = CMD_CINIT;
                n_step    = '0;
                n_state   = ST_CROT;
            end
            ST_CROT: begin
                o_ctl.cmd = CMD_CSTEP;
                n_step    = r_step + 1'b1;
                if (r_step == LAST_STEP) n_state = ST_CFIN;
            end
            ST_CFIN: begin
                o_ctl.cmd = CMD_CFIN;
                n_axis    = 1'b0;
                n_state   = ST_MHI;
            end
            ST_MHI: begin
                o_ctl.cmd = CMD_MHI;
                n_state   = ST_MLO;
            end
            ST_MLO: begin
                o_ctl.cmd = CMD_MLO;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_ctl.cmd = CMD_SCALE;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_ctl.cmd = CMD_ACC;
                n_axis    = 1'b1;
                n_state   = r_axis ? ST_OUT : ST_MHI;
            end
            ST_OUT: begin
                // The result register is loaded once the previous item has left.
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.cmd   = CMD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    // A capture item goes straight to the result stage.
    a_capture_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_in_op == OP_CAPTURE) |=> (r_state == ST_OUT))
        else $error("capture item did not go to the result stage");

    // The rotation counter never runs past the last step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CROT) |-> (r_step <= LAST_STEP))
        else $error("CORDIC step counter out of range");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.cmd == CMD_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while occupied");

    // The datapath only loads the counts from an item that has been accepted.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.cmd == CMD_LOAD) |-> (o_in_ready && i_in_valid))
        else $error("counts loaded without an accepted item");

endmodule
`default_nettype wire

// File: rtl/core/differential_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
// Flow: a capture item goes from acceptance straight to the result stage; an update item
// first runs the gain multiplies, the CORDIC rotation and the scaling of both axes.
// Items are taken one at a time: a new item is accepted only once the previous one has
// been sequenced through and its result loaded, which waits while the output is stalled.
// Reset is synchronous and active low: pose and baselines clear, gains take their defaults.
`default_nettype none
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ddo_pkg::GAIN_W-1:0]     i_cfg_data,
    ddo_in_if.sink                              i_in,
    ddo_out_if.source                           o_out
);
    import ddo_pkg::*;

    t_ctl ctl;

    // Sequencer.
    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_ctl       (ctl)
    );

    // Arithmetic and state.
    ddo_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_left_count  (i_in.left_count),
        .i_right_count (i_in.right_count),
        .o_pos_x       (o_out.pos_x),
        .o_pos_y       (o_out.pos_y),
        .o_heading     (o_out.heading),
        .o_saturated   (o_out.saturated)
    );

endmodule
`default_nettype wire
